// ===== src/sorted_unique_key_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Sorted unique key table: assertion macros
// Shared concurrent assertion forms used by the table's RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_UNIQUE_KEY_TABLE_UNIT_ASSERT_SVH
`define SORTED_UNIQUE_KEY_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SUKT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sukt: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SUKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sukt: next-cycle check failed");

`endif

// ===== src/sukt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key table package
// Field widths, operation and status codes, controller states and the
// result record shared by the table's modules.
// ----------------------------------------------------------------------------
package sukt_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int KEY_W            = 32;
   localparam int FUNC_W           = 2;
   localparam int STATUS_W         = 3;
   localparam int POS_W            = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_LIST   = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 3'd0,
      STATUS_DUP     = 3'd1,
      STATUS_FULL    = 3'd2,
      STATUS_MISSING = 3'd3,
      STATUS_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT_UP,
      ST_SHIFT_DN,
      ST_PLACE,
      ST_RESP,
      ST_LIST
   } state_type;

   typedef struct packed {
      status_type               status;
      logic signed [KEY_W-1:0]  result_key;
      logic [POS_W-1:0]         position;
      logic                     last;
   } result_type;

endpackage

// ===== src/sukt_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table operation and its key.
// ----------------------------------------------------------------------------
interface sukt_req_if;
   import sukt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic signed [KEY_W-1:0] key;

   modport source (output valid, output func, output key, input ready);
   modport sink (input valid, input func, input key, output ready);
endinterface

// ===== src/sukt_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result record of the table.
// ----------------------------------------------------------------------------
interface sukt_rsp_if;
   import sukt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STATUS_W-1:0]     status;
   logic signed [KEY_W-1:0] result_key;
   logic [POS_W-1:0]        position;
   logic                    last;

   modport source (output valid, output status, output result_key, output position,
                   output last, input ready);
   modport sink (input valid, input status, input result_key, input position,
                 input last, output ready);
endinterface

// ===== src/sukt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sukt_ram #(
   parameter int  CAPACITY = sukt_pkg::DEFAULT_CAPACITY,
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic signed [sukt_pkg::KEY_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic signed [sukt_pkg::KEY_W-1:0] rd_data
);
   import sukt_pkg::*;

   logic signed [KEY_W-1:0] key_mem [CAPACITY];
   logic signed [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= key_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sukt_rsp_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response output register
// Holds one result until the downstream transfer completes.
// ----------------------------------------------------------------------------
module sukt_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sukt_pkg::result_type result,
   output logic                 out_free,
   sukt_rsp_if.source           rsp_chan
);
   import sukt_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // The register can take a new result when empty or when it drains this cycle.
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.status     = data_ff.status;
   assign rsp_chan.result_key = data_ff.result_key;
   assign rsp_chan.position   = data_ff.position;
   assign rsp_chan.last       = data_ff.last;

endmodule

// ===== src/sukt_ctrl.sv =====
`timescale 1ns / 1ps
`include "sorted_unique_key_table_unit_assert.svh"
// ----------------------------------------------------------------------------
// Table controller
// Scans the key memory for the sorted position, shifts entries to open or
// close a slot, and streams the list of keys to the response register.
// ----------------------------------------------------------------------------
module sukt_ctrl #(
   parameter int  CAPACITY = sukt_pkg::DEFAULT_CAPACITY,
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   sukt_req_if.sink                          req_chan,
   output logic                              mem_we,
   output logic [ADDR_W-1:0]                 mem_waddr,
   output logic signed [sukt_pkg::KEY_W-1:0] mem_wdata,
   output logic [ADDR_W-1:0]                 mem_raddr,
   input  logic signed [sukt_pkg::KEY_W-1:0] mem_rdata,
   output logic                              rsp_load,
   output sukt_pkg::result_type              rsp_result,
   input  logic                              out_free
);
   import sukt_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type               state_ff, state_in;
   func_type                func_ff, func_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic                    match_ff, match_in;
   status_type              status_ff, status_in;

   logic [CNT_W-1:0] idx_inc, idx_inc2, idx_dec, idx_dec2;
   logic [CNT_W-1:0] count_inc, count_dec, pos_inc;
   logic             req_fire;
   logic             write_state;

   assign idx_inc   = idx_ff + CNT_W'(1);
   assign idx_inc2  = idx_ff + CNT_W'(2);
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign idx_dec2  = idx_ff - CNT_W'(2);
   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign pos_inc   = pos_ff + CNT_W'(1);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      match_in   = match_ff;
      status_in  = status_ff;
      mem_we     = 1'b0;
      mem_waddr  = pos_ff[ADDR_W-1:0];
      mem_wdata  = key_ff;
      mem_raddr  = '0;
      rsp_load   = 1'b0;
      rsp_result.status     = status_ff;
      rsp_result.result_key = '0;
      rsp_result.position   = '0;
      rsp_result.last       = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            // Entry zero is read here so a scan or list can start next cycle.
            mem_raddr = '0;
            if (req_fire) begin
               func_in = func_type'(req_chan.func);
               key_in  = req_chan.key;
               idx_in  = '0;
               case (func_type'(req_chan.func))
                  FUNC_INSERT: begin
                     state_in = ST_SCAN;
                  end
                  FUNC_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_LIST: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_LIST;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // One entry per cycle; the next entry is already being read.
            mem_raddr = idx_inc[ADDR_W-1:0];
            if (idx_ff == count_ff) begin
               pos_in   = idx_ff;
               match_in = 1'b0;
               state_in = ST_DECIDE;
            end else if (mem_rdata >= key_ff) begin
               pos_in   = idx_ff;
               match_in = (mem_rdata == key_ff);
               state_in = ST_DECIDE;
            end else begin
               idx_in = idx_inc;
            end
         end

         ST_DECIDE: begin
            if (func_ff == FUNC_INSERT) begin
               mem_raddr = count_dec[ADDR_W-1:0];
               if (match_ff) begin
                  status_in = STATUS_DUP;
                  state_in  = ST_RESP;
               end else if (count_ff == CNT_W'(CAPACITY)) begin
                  status_in = STATUS_FULL;
                  state_in  = ST_RESP;
               end else if (pos_ff == count_ff) begin
                  state_in = ST_PLACE;
               end else begin
                  idx_in   = count_ff;
                  state_in = ST_SHIFT_UP;
               end
            end else begin
               mem_raddr = pos_inc[ADDR_W-1:0];
               if (!match_ff) begin
                  status_in = STATUS_MISSING;
                  state_in  = ST_RESP;
               end else if (pos_inc == count_ff) begin
                  count_in  = count_dec;
                  status_in = STATUS_OK;
                  state_in  = ST_RESP;
               end else begin
                  idx_in   = pos_ff;
                  state_in = ST_SHIFT_DN;
               end
            end
         end

         ST_SHIFT_UP: begin
            // Entry idx-1 arrived from the read issued last cycle.
            mem_we    = 1'b1;
            mem_waddr = idx_ff[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            mem_raddr = idx_dec2[ADDR_W-1:0];
            idx_in    = idx_dec;
            if (idx_dec == pos_ff) begin
               state_in = ST_PLACE;
            end
         end

         ST_SHIFT_DN: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            mem_raddr = idx_inc2[ADDR_W-1:0];
            idx_in    = idx_inc;
            if (idx_inc2 == count_ff) begin
               count_in  = count_dec;
               status_in = STATUS_OK;
               state_in  = ST_RESP;
            end
         end

         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff[ADDR_W-1:0];
            mem_wdata = key_ff;
            count_in  = count_inc;
            status_in = STATUS_OK;
            state_in  = ST_RESP;
         end

         ST_RESP: begin
            if (status_ff == STATUS_OK) begin
               rsp_result.result_key = key_ff;
               rsp_result.position   = POS_W'(pos_ff) + POS_W'(1);
            end
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         ST_LIST: begin
            rsp_result.status     = STATUS_OK;
            rsp_result.result_key = mem_rdata;
            rsp_result.position   = POS_W'(idx_ff) + POS_W'(1);
            rsp_result.last       = (idx_inc == count_ff);
            // Hold the read address while stalled so the data stays put.
            mem_raddr = idx_ff[ADDR_W-1:0];
            if (out_free) begin
               rsp_load  = 1'b1;
               mem_raddr = idx_inc[ADDR_W-1:0];
               idx_in    = idx_inc;
               if (idx_inc == count_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      key_ff    <= key_in;
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      match_ff  <= match_in;
      status_ff <= status_in;
   end

   assign write_state = (state_ff == ST_SHIFT_UP) || (state_ff == ST_SHIFT_DN) ||
                        (state_ff == ST_PLACE);

   `SUKT_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `SUKT_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == ST_SCAN, idx_ff <= count_ff)
   `SUKT_ASSERT_IMP(a_write_state, clock, reset, mem_we, write_state)
   `SUKT_ASSERT_NEXT(a_place_grows, clock, reset, state_ff == ST_PLACE, count_ff == $past(count_inc))
   `SUKT_ASSERT_IMP(a_load_free, clock, reset, rsp_load, out_free)

endmodule

// ===== src/sorted_unique_key_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted unique key table unit
// Ordered set of distinct signed keys with insert, delete and list requests.
// ----------------------------------------------------------------------------
// Keys live in ascending order in a single-port-read key memory, so a request
// on a non-empty table walks that memory one entry per cycle unless the
// response side holds it. In an insert or delete, the scan reads entries up
// to the key's position, then one entry per cycle is moved to open or close a
// slot. A list request gives one result per cycle, as long as the response
// side keeps taking them. A new request is taken once the previous one has
// handed its last result to the output register. No clearing pass is needed
// after reset: only entries below the count are used.
module sorted_unique_key_table_unit #(
   parameter int CAPACITY = sukt_pkg::DEFAULT_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   sukt_req_if.sink    req_chan,
   sukt_rsp_if.source  rsp_chan
);
   import sukt_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   logic signed [KEY_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]       mem_raddr;
   logic signed [KEY_W-1:0] mem_rdata;
   logic                    rsp_load;
   result_type              rsp_result;
   logic                    out_free;

   sukt_ram #(.CAPACITY(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   sukt_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .rsp_load   (rsp_load),
      .rsp_result (rsp_result),
      .out_free   (out_free)
   );

   sukt_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (rsp_load),
      .result   (rsp_result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
